// ===== design/holonomic_wheel_mixer_assert.svh =====
// Assertion macros shared by the holonomic wheel mixer RTL.
`ifndef HOLONOMIC_WHEEL_MIXER_ASSERT_SVH
`define HOLONOMIC_WHEEL_MIXER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define HWM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("holonomic_wheel_mixer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HWM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("holonomic_wheel_mixer: next-cycle check failed");

`else

`define HWM_ASSERT_IMP(name, clk, rstn, ante, cons)
`define HWM_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== design/hwm_pkg.sv =====
// Package with the constants, types and sine table of the holonomic wheel mixer.
`default_nettype none

package hwm_pkg;

    localparam int IN_W              = 9;
    localparam int ANG_W             = 9;
    localparam int IDX_W             = 7;
    localparam int DUTY_W            = 8;
    localparam int MAG_W             = 10;
    localparam int NUM_W             = 18;
    localparam int WHEELS            = 4;
    localparam int W_FL              = 0;
    localparam int W_FR              = 1;
    localparam int W_RL              = 2;
    localparam int W_RR              = 3;
    localparam int PWM_MAX           = 255;
    localparam int ANGLE_OFFSET      = 45;
    localparam int QUARTER_TURN      = 90;
    localparam int HALF_TURN         = 180;
    localparam int THREE_QUARTER     = 270;
    localparam int FULL_TURN         = 360;
    localparam int TABLE_Q_BITS      = 16;
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int DIV_STAGES        = 4;
    localparam int DIV_STEPS         = DUTY_W / DIV_STAGES;

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [DUTY_W-1:0] duty_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // Sine of 0..90 degrees scaled by 2^16 and rounded.
    localparam int SINE_Q16 [0:QUARTER_TURN] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14743, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35694, 36647, 37590, 38521, 39440, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50204, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62329, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    // Table entry for k degrees reduced to frac_bits fraction bits, rounding half up.
    function automatic logic [TABLE_Q_BITS:0] trig_entry(input idx_t k, input int frac_bits);
        int t;
        int sh;
        begin
            t  = SINE_Q16[(k > idx_t'(QUARTER_TURN)) ? idx_t'(QUARTER_TURN) : k];
            sh = TABLE_Q_BITS - frac_bits;
            if (sh > 0) begin
                t = (t + (1 << (sh - 1))) >> sh;
            end
            trig_entry = (TABLE_Q_BITS + 1)'(t);
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/holonomic_wheel_mixer.sv =====
// Holonomic wheel mixer top level: drive command in, four wheel direction and duty values out.
// An accepted request passes through the register stages to its result on the m_ channel.
// One request per cycle unless stalled; each stage has its own valid bit, so bubbles close up.
// The depth is set by the eleven register stages, four of which form the rescale divider.
// aresetn is synchronous and active low; it clears only the stage valid bits.
`default_nettype none
`include "holonomic_wheel_mixer_assert.svh"

module holonomic_wheel_mixer #(
    parameter int TRIG_FRAC_BITS = hwm_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [hwm_pkg::IN_W-1:0]   s_drive_speed,
    input  logic        [hwm_pkg::ANG_W-1:0]  s_heading_deg,
    input  logic signed [hwm_pkg::IN_W-1:0]   s_turn_rate,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_dir_front_left,
    output logic        [hwm_pkg::DUTY_W-1:0] m_duty_front_left,
    output logic                              m_dir_front_right,
    output logic        [hwm_pkg::DUTY_W-1:0] m_duty_front_right,
    output logic                              m_dir_rear_left,
    output logic        [hwm_pkg::DUTY_W-1:0] m_duty_rear_left,
    output logic                              m_dir_rear_right,
    output logic        [hwm_pkg::DUTY_W-1:0] m_duty_rear_right
);
    import hwm_pkg::*;

    // Signed trig values carry one integer bit and a sign bit on top of the fraction.
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W = TRIG_W + IN_W;
    localparam int SUM_W  = PROD_W + 1;

    // Stage numbering. The divider occupies the stages after ST_MAX.
    localparam int ST_ANG  = 1;
    localparam int ST_QUAD = 2;
    localparam int ST_TRIG = 3;
    localparam int ST_MUL  = 4;
    localparam int ST_MIX  = 5;
    localparam int ST_MAX  = 6;
    localparam int ST_OUT  = ST_MAX + DIV_STAGES + 1;

    // ------------------------------------------------------------------
    // Flow control. A stage loads whenever it is empty or its contents
    // move on in the same cycle, so a stall at the output only backs up
    // as far as the first empty stage and a request can still be taken
    // while a finished result waits.
    // ------------------------------------------------------------------
    logic [ST_OUT:1]   vld_reg;
    logic [ST_OUT:1]   vld_in;
    logic [ST_OUT+1:1] rdy;

    assign vld_in         = {vld_reg[ST_OUT-1:1], s_valid};
    assign rdy[ST_OUT+1]  = m_ready;

    for (genvar k = 1; k <= ST_OUT; k++) begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= ST_OUT; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign s_ready = rdy[ST_ANG];
    assign m_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Stage 1: angle = heading + 45 degrees, wrapped once into 0..359.
    // Headings up to 511 are accepted, so one subtraction always suffices.
    // ------------------------------------------------------------------
    logic [ANG_W:0]          ang_sum;
    logic [ANG_W-1:0]        ang_next;
    logic [ANG_W-1:0]        ang_reg;
    logic signed [IN_W-1:0]  speed1_reg;
    logic signed [IN_W-1:0]  rot1_reg;

    assign ang_sum  = {1'b0, s_heading_deg} + (ANG_W+1)'(ANGLE_OFFSET);
    assign ang_next = (ang_sum >= (ANG_W+1)'(FULL_TURN))
                    ? ANG_W'(ang_sum - (ANG_W+1)'(FULL_TURN))
                    : ang_sum[ANG_W-1:0];

    always_ff @(posedge aclk) begin
        if (rdy[ST_ANG]) begin
            ang_reg    <= ang_next;
            speed1_reg <= s_drive_speed;
            rot1_reg   <= s_turn_rate;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: split the angle into a quadrant and a remainder. The cosine
    // uses the same remainder one quadrant further on, since
    // cos(a) = sin(a + 90). Odd quadrants read the table mirrored.
    // ------------------------------------------------------------------
    logic [1:0]             quad;
    logic [1:0]             cquad;
    logic [ANG_W-1:0]       ang_rem;
    idx_t                   rem_idx;
    idx_t                   idx_s_next;
    idx_t                   idx_c_next;
    idx_t                   idx_s_reg;
    idx_t                   idx_c_reg;
    logic                   neg_s_reg;
    logic                   neg_c_reg;
    logic signed [IN_W-1:0] speed2_reg;
    logic signed [IN_W-1:0] rot2_reg;

    always_comb begin
        if (ang_reg >= ANG_W'(THREE_QUARTER)) begin
            quad    = 2'd3;
            ang_rem = ang_reg - ANG_W'(THREE_QUARTER);
        end else if (ang_reg >= ANG_W'(HALF_TURN)) begin
            quad    = 2'd2;
            ang_rem = ang_reg - ANG_W'(HALF_TURN);
        end else if (ang_reg >= ANG_W'(QUARTER_TURN)) begin
            quad    = 2'd1;
            ang_rem = ang_reg - ANG_W'(QUARTER_TURN);
        end else begin
            quad    = 2'd0;
            ang_rem = ang_reg;
        end
        cquad      = quad + 2'd1;
        rem_idx    = ang_rem[IDX_W-1:0];
        idx_s_next = quad[0]  ? idx_t'(QUARTER_TURN) - rem_idx : rem_idx;
        idx_c_next = cquad[0] ? idx_t'(QUARTER_TURN) - rem_idx : rem_idx;
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_QUAD]) begin
            idx_s_reg  <= idx_s_next;
            idx_c_reg  <= idx_c_next;
            neg_s_reg  <= quad[1];
            neg_c_reg  <= cquad[1];
            speed2_reg <= speed1_reg;
            rot2_reg   <= rot1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quarter-wave table lookup and sign for sine and cosine.
    // ------------------------------------------------------------------
    logic [TABLE_Q_BITS:0]    ent_s;
    logic [TABLE_Q_BITS:0]    ent_c;
    logic signed [TRIG_W-1:0] pos_s;
    logic signed [TRIG_W-1:0] pos_c;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [IN_W-1:0]   speed3_reg;
    logic signed [IN_W-1:0]   rot3_reg;

    assign ent_s    = trig_entry(idx_s_reg, TRIG_FRAC_BITS);
    assign ent_c    = trig_entry(idx_c_reg, TRIG_FRAC_BITS);
    assign pos_s    = TRIG_W'(ent_s[TRIG_FRAC_BITS:0]);
    assign pos_c    = TRIG_W'(ent_c[TRIG_FRAC_BITS:0]);
    assign sin_next = neg_s_reg ? -pos_s : pos_s;
    assign cos_next = neg_c_reg ? -pos_c : pos_c;

    always_ff @(posedge aclk) begin
        if (rdy[ST_TRIG]) begin
            sin_reg    <= sin_next;
            cos_reg    <= cos_next;
            speed3_reg <= speed2_reg;
            rot3_reg   <= rot2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: speed times sine and speed times cosine, kept exact.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] ps_next;
    logic signed [PROD_W-1:0] pc_next;
    logic signed [PROD_W-1:0] ps_reg;
    logic signed [PROD_W-1:0] pc_reg;
    logic signed [IN_W-1:0]   rot4_reg;

    assign ps_next = PROD_W'(speed3_reg) * PROD_W'(sin_reg);
    assign pc_next = PROD_W'(speed3_reg) * PROD_W'(cos_reg);

    always_ff @(posedge aclk) begin
        if (rdy[ST_MUL]) begin
            ps_reg   <= ps_next;
            pc_reg   <= pc_next;
            rot4_reg <= rot3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add or subtract the rotation at the same scale, then drop
    // the fraction toward zero by working on sign and magnitude. A mix
    // that truncates to zero counts as nonnegative.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] rs;
    logic signed [SUM_W-1:0] mix_sum [WHEELS];
    logic [SUM_W-1:0]        mix_abs [WHEELS];
    logic [SUM_W-1:0]        mix_shr [WHEELS];
    mag_t                    mag5_next [WHEELS];
    logic [WHEELS-1:0]       neg5_next;
    mag_t                    mag5_reg [WHEELS];
    logic [WHEELS-1:0]       neg5_reg;

    assign rs = SUM_W'(rot4_reg) <<< TRIG_FRAC_BITS;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            // Front-left and rear-right mix the sine, the other two the cosine.
            if (i == W_FR || i == W_RL) begin
                mix_sum[i] = SUM_W'(pc_reg);
            end else begin
                mix_sum[i] = SUM_W'(ps_reg);
            end
            if (i == W_FR || i == W_RR) begin
                mix_sum[i] = mix_sum[i] - rs;
            end else begin
                mix_sum[i] = mix_sum[i] + rs;
            end
            mix_abs[i]   = mix_sum[i][SUM_W-1] ? SUM_W'(-mix_sum[i]) : SUM_W'(mix_sum[i]);
            mix_shr[i]   = mix_abs[i] >> TRIG_FRAC_BITS;
            mag5_next[i] = mix_shr[i][MAG_W-1:0];
            neg5_next[i] = mix_sum[i][SUM_W-1] && (mag5_next[i] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_MIX]) begin
            mag5_reg <= mag5_next;
            neg5_reg <= neg5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: largest magnitude, rescale decision and the dividend
    // 255 * |v| for each wheel. This is entry 0 of the divider arrays.
    // ------------------------------------------------------------------
    num_t              rem_reg  [DIV_STAGES+1][WHEELS];
    duty_t             quo_reg  [DIV_STAGES+1][WHEELS];
    mag_t              dmag_reg [DIV_STAGES+1][WHEELS];
    logic [WHEELS-1:0] dneg_reg [DIV_STAGES+1];
    mag_t              dmax_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0] scale_reg;

    mag_t max01;
    mag_t max23;
    mag_t max_all;
    num_t num_next [WHEELS];

    num_t  rem_next [DIV_STAGES+1][WHEELS];
    duty_t quo_next [DIV_STAGES+1][WHEELS];

    assign max01   = (mag5_reg[W_FL] > mag5_reg[W_FR]) ? mag5_reg[W_FL] : mag5_reg[W_FR];
    assign max23   = (mag5_reg[W_RL] > mag5_reg[W_RR]) ? mag5_reg[W_RL] : mag5_reg[W_RR];
    assign max_all = (max01 > max23) ? max01 : max23;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            num_next[i] = (NUM_W'(mag5_reg[i]) << DUTY_W) - NUM_W'(mag5_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Divider: restoring division of 255 * |v| by the maximum, two
    // quotient bits per stage, most significant first. Since |v| never
    // exceeds the maximum the quotient fits in eight bits.
    // ------------------------------------------------------------------
    always_comb begin
        num_t  r;
        duty_t q;
        num_t  d;
        int    bp;
        for (int i = 0; i < WHEELS; i++) begin
            rem_next[0][i] = num_next[i];
            quo_next[0][i] = '0;
        end
        for (int j = 1; j <= DIV_STAGES; j++) begin
            for (int i = 0; i < WHEELS; i++) begin
                r = rem_reg[j-1][i];
                q = quo_reg[j-1][i];
                for (int t = 0; t < DIV_STEPS; t++) begin
                    bp = DUTY_W - 1 - (j - 1) * DIV_STEPS - t;
                    d  = NUM_W'(dmax_reg[j-1]) << bp;
                    if (r >= d) begin
                        r     = r - d;
                        q[bp] = 1'b1;
                    end
                end
                rem_next[j][i] = r;
                quo_next[j][i] = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_MAX]) begin
            dmag_reg[0]  <= mag5_reg;
            dneg_reg[0]  <= neg5_reg;
            dmax_reg[0]  <= max_all;
            scale_reg[0] <= (max_all > MAG_W'(PWM_MAX));
        end
        for (int j = 0; j <= DIV_STAGES; j++) begin
            if (rdy[ST_MAX + j]) begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
            end
        end
        for (int j = 1; j <= DIV_STAGES; j++) begin
            if (rdy[ST_MAX + j]) begin
                dmag_reg[j]  <= dmag_reg[j-1];
                dneg_reg[j]  <= dneg_reg[j-1];
                dmax_reg[j]  <= dmax_reg[j-1];
                scale_reg[j] <= scale_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: pick the rescaled or the plain magnitude and set the
    // direction pins. A negative mix that rescales to zero becomes zero
    // and so nonnegative. The right-hand motors are wired reversed.
    // ------------------------------------------------------------------
    duty_t             duty_next [WHEELS];
    logic [WHEELS-1:0] negf;
    duty_t             duty_reg  [WHEELS];
    logic [WHEELS-1:0] dir_reg;
    logic [WHEELS-1:0] dir_next;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            if (scale_reg[DIV_STAGES]) begin
                duty_next[i] = quo_reg[DIV_STAGES][i];
                negf[i]      = dneg_reg[DIV_STAGES][i] && (quo_reg[DIV_STAGES][i] != '0);
            end else begin
                duty_next[i] = dmag_reg[DIV_STAGES][i][DUTY_W-1:0];
                negf[i]      = dneg_reg[DIV_STAGES][i];
            end
        end
        dir_next[W_FL] = negf[W_FL];
        dir_next[W_FR] = !negf[W_FR];
        dir_next[W_RL] = negf[W_RL];
        dir_next[W_RR] = !negf[W_RR];
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            duty_reg <= duty_next;
            dir_reg  <= dir_next;
        end
    end

    assign m_dir_front_left   = dir_reg[W_FL];
    assign m_duty_front_left  = duty_reg[W_FL];
    assign m_dir_front_right  = dir_reg[W_FR];
    assign m_duty_front_right = duty_reg[W_FR];
    assign m_dir_rear_left    = dir_reg[W_RL];
    assign m_duty_rear_left   = duty_reg[W_RL];
    assign m_dir_rear_right   = dir_reg[W_RR];
    assign m_duty_rear_right  = duty_reg[W_RR];

    // ------------------------------------------------------------------
    // Checks on the pipeline's own logic.
    // ------------------------------------------------------------------

    // An accepted request always occupies the first stage next cycle.
    `HWM_ASSERT_NXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, vld_reg[ST_ANG])

    // Without rescaling every magnitude already fits the duty width.
    `HWM_ASSERT_IMP(a_plain_fits, aclk, aresetn, vld_reg[ST_OUT-1] && !scale_reg[DIV_STAGES], (dmag_reg[DIV_STAGES][W_FL][MAG_W-1:DUTY_W] == '0) && (dmag_reg[DIV_STAGES][W_FR][MAG_W-1:DUTY_W] == '0) && (dmag_reg[DIV_STAGES][W_RL][MAG_W-1:DUTY_W] == '0) && (dmag_reg[DIV_STAGES][W_RR][MAG_W-1:DUTY_W] == '0))

    // After the last divider stage each remainder is below the divisor.
    `HWM_ASSERT_IMP(a_div_done, aclk, aresetn, vld_reg[ST_OUT-1] && scale_reg[DIV_STAGES], (rem_reg[DIV_STAGES][W_FL] < NUM_W'(dmax_reg[DIV_STAGES])) && (rem_reg[DIV_STAGES][W_FR] < NUM_W'(dmax_reg[DIV_STAGES])) && (rem_reg[DIV_STAGES][W_RL] < NUM_W'(dmax_reg[DIV_STAGES])) && (rem_reg[DIV_STAGES][W_RR] < NUM_W'(dmax_reg[DIV_STAGES])))

endmodule

`default_nettype wire

// ===== dv/holonomic_wheel_mixer_test.sv =====
// Self-checking testbench for holonomic_wheel_mixer: drive requests in, wheel commands checked out.
`default_nettype none

module holonomic_wheel_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hwm_pkg::*;

    // The block runs with its default trig precision, and the predictor uses the same value.
    localparam int FRAC_BITS  = TRIG_FRAC_BITS_DEF;
    localparam int RAND_CMDS  = 1300;
    // Roughly 1325 requests under the worst idling; the cap lies far above what the run needs.
    localparam int CYCLE_CAP  = 200000;
    // Length of the deliberate receiver hold-off; well beyond the eleven-stage pipeline depth.
    localparam int HOLD_LEN   = 60;
    // Cycles allowed after the last expected result for any stray output to show up.
    localparam int DRAIN_LEN  = 40;

    // One drive request as it enters the block.
    typedef struct {
        logic signed [IN_W-1:0] speed;
        logic [ANG_W-1:0]       heading;
        logic signed [IN_W-1:0] turn;
    } drive_cmd_t;

    // Direction pins and duty values of all four wheels, indexed by the package wheel order.
    typedef struct packed {
        logic [WHEELS-1:0]             dir;
        logic [WHEELS-1:0][DUTY_W-1:0] duty;
    } wheel_cmd_t;

    logic                      aclk;
    logic                      aresetn            = 1'b0;
    logic                      s_valid            = 1'b0;
    logic                      s_ready;
    logic signed [IN_W-1:0]    s_drive_speed      = '0;
    logic        [ANG_W-1:0]   s_heading_deg      = '0;
    logic signed [IN_W-1:0]    s_turn_rate        = '0;
    logic                      m_valid;
    logic                      m_ready            = 1'b0;
    logic                      m_dir_front_left;
    logic        [DUTY_W-1:0]  m_duty_front_left;
    logic                      m_dir_front_right;
    logic        [DUTY_W-1:0]  m_duty_front_right;
    logic                      m_dir_rear_left;
    logic        [DUTY_W-1:0]  m_duty_rear_left;
    logic                      m_dir_rear_right;
    logic        [DUTY_W-1:0]  m_duty_rear_right;

    drive_cmd_t pending_cmds[$];
    wheel_cmd_t expected_wheels[$];

    int  total_cmds    = 0;
    int  cmds_taken    = 0;
    int  mismatch_cnt  = 0;
    int  cycle_cnt     = 0;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  req_taken     = 1'b0;
    bit  rx_hold       = 1'b0;

    string wheel_name [WHEELS] = '{"front_left", "front_right", "rear_left", "rear_right"};

    holonomic_wheel_mixer #(
        .TRIG_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_drive_speed      (s_drive_speed),
        .s_heading_deg      (s_heading_deg),
        .s_turn_rate        (s_turn_rate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_dir_front_left   (m_dir_front_left),
        .m_duty_front_left  (m_duty_front_left),
        .m_dir_front_right  (m_dir_front_right),
        .m_duty_front_right (m_duty_front_right),
        .m_dir_rear_left    (m_dir_rear_left),
        .m_duty_rear_left   (m_duty_rear_left),
        .m_dir_rear_right   (m_dir_rear_right),
        .m_duty_rear_right  (m_duty_rear_right)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Sine of a whole-degree angle in 0..359 with FRAC_BITS fraction bits. The quarter-wave
    // table is folded by quadrant, and each entry is rounded half up from its 16-bit form.
    function automatic int sine_at(input int angle);
        int quad;
        int rem;
        int idx;
        int shift;
        int mag;
        begin
            quad  = angle / QUARTER_TURN;
            rem   = angle % QUARTER_TURN;
            idx   = quad[0] ? (QUARTER_TURN - rem) : rem;
            shift = TABLE_Q_BITS - FRAC_BITS;
            mag   = SINE_Q16[idx];
            if (shift > 0) begin
                mag = (mag + (1 << (shift - 1))) >> shift;
            end
            sine_at = (quad >= 2) ? -mag : mag;
        end
    endfunction

    // Expected wheel command for one drive request. Each mix is the exact fixed-point sum,
    // truncated toward zero as a whole; if any magnitude exceeds full duty, all four are
    // scaled by 255/peak with C-style integer division, then split into pin and magnitude.
    function automatic wheel_cmd_t mix_wheels(input drive_cmd_t cmd);
        int angle;
        int sin_v;
        int cos_v;
        int spin;
        int along_sin;
        int along_cos;
        int peak;
        int mag;
        int mix [WHEELS];
        wheel_cmd_t res;
        begin
            angle     = (int'(cmd.heading) + ANGLE_OFFSET) % FULL_TURN;
            sin_v     = sine_at(angle);
            cos_v     = sine_at((angle + QUARTER_TURN) % FULL_TURN);
            spin      = int'(cmd.turn) * (1 << FRAC_BITS);
            along_sin = int'(cmd.speed) * sin_v;
            along_cos = int'(cmd.speed) * cos_v;
            mix[W_FL] = along_sin + spin;
            mix[W_FR] = along_cos - spin;
            mix[W_RL] = along_cos + spin;
            mix[W_RR] = along_sin - spin;
            peak = 0;
            for (int i = 0; i < WHEELS; i++) begin
                mix[i] = (mix[i] < 0) ? -((-mix[i]) >>> FRAC_BITS) : (mix[i] >>> FRAC_BITS);
                mag    = (mix[i] < 0) ? -mix[i] : mix[i];
                if (mag > peak) begin
                    peak = mag;
                end
            end
            for (int i = 0; i < WHEELS; i++) begin
                if (peak > PWM_MAX) begin
                    mix[i] = (PWM_MAX * mix[i]) / peak;
                end
                mag = (mix[i] < 0) ? -mix[i] : mix[i];
                if (mag > PWM_MAX) begin
                    mag = PWM_MAX;
                end
                // Left wheels raise the pin on a negative mix, right wheels on a nonnegative one.
                res.dir[i]  = (i % 2 == 1) ? (mix[i] >= 0) : (mix[i] < 0);
                res.duty[i] = DUTY_W'(mag);
            end
            mix_wheels = res;
        end
    endfunction

    task automatic queue_cmd(input int speed, input int heading, input int turn);
        drive_cmd_t cmd;
        begin
            cmd.speed   = IN_W'(speed);
            cmd.heading = ANG_W'(heading);
            cmd.turn    = IN_W'(turn);
            pending_cmds.push_back(cmd);
        end
    endtask

    // Idling schedule, keyed to how many requests have gone in. The sender idles lightly
    // and the receiver heavily first, then the reverse, then neither side idles at all.
    always_comb begin
        if (cmds_taken < total_cmds / 3) begin
            tx_idle_pct = 22;
            rx_idle_pct = 47;
        end else if (cmds_taken < 2 * total_cmds / 3) begin
            tx_idle_pct = 47;
            rx_idle_pct = 22;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // Request driver. A new request is presented only once the previous one was taken
    // (or nothing was on offer), so valid and payload stay put while the block stalls.
    always @(negedge aclk) begin : request_driver
        drive_cmd_t cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cmd            = pending_cmds.pop_front();
                s_valid       <= 1'b1;
                s_drive_speed <= cmd.speed;
                s_heading_deg <= cmd.heading;
                s_turn_rate   <= cmd.turn;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, or a solid stall while the hold-off runs.
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor on the rising edge. The result side is checked before the request side is
    // recorded, so a request taken at this edge can never be matched against this result.
    always @(posedge aclk) begin : monitor
        wheel_cmd_t want;
        wheel_cmd_t got;
        drive_cmd_t cmd;
        cycle_cnt <= cycle_cnt + 1;
        req_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            got.dir[W_FL]  = m_dir_front_left;
            got.duty[W_FL] = m_duty_front_left;
            got.dir[W_FR]  = m_dir_front_right;
            got.duty[W_FR] = m_duty_front_right;
            got.dir[W_RL]  = m_dir_rear_left;
            got.duty[W_RL] = m_duty_rear_left;
            got.dir[W_RR]  = m_dir_rear_right;
            got.duty[W_RR] = m_duty_rear_right;
            if (expected_wheels.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_cnt++;
            end else begin
                want = expected_wheels.pop_front();
                for (int i = 0; i < WHEELS; i++) begin
                    if (got.dir[i] !== want.dir[i]) begin
                        $error("dir_%s: expected %0d, got %0d",
                               wheel_name[i], want.dir[i], got.dir[i]);
                        mismatch_cnt++;
                    end
                    if (got.duty[i] !== want.duty[i]) begin
                        $error("duty_%s: expected %0d, got %0d",
                               wheel_name[i], want.duty[i], got.duty[i]);
                        mismatch_cnt++;
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            cmd.speed   = s_drive_speed;
            cmd.heading = s_heading_deg;
            cmd.turn    = s_turn_rate;
            expected_wheels.push_back(mix_wheels(cmd));
            cmds_taken <= cmds_taken + 1;
        end
    end

    // Long receiver stall in the no-idle phase. The sender keeps offering requests, so
    // the pipeline fills up and s_ready has to drop until the receiver lets go.
    initial begin
        wait (total_cmds != 0);
        while (cmds_taken < 2 * total_cmds / 3 + 50) begin
            @(posedge aclk);
        end
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        wait (cycle_cnt >= CYCLE_CAP);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        // Directed requests first. All zero gives a zero peak and therefore no rescale.
        queue_cmd(0, 0, 0);
        // Speed extremes, including the one negative value past the nominal range.
        queue_cmd(255, 0, 0);
        queue_cmd(-255, 0, 0);
        queue_cmd(-256, 0, 0);
        // Headings landing on each quadrant boundary of the offset angle, midway between, and the last degree.
        queue_cmd(200, 45, 0);
        queue_cmd(200, 135, 0);
        queue_cmd(200, 225, 0);
        queue_cmd(200, 315, 0);
        queue_cmd(-200, 90, 0);
        queue_cmd(-200, 180, 0);
        queue_cmd(-200, 270, 0);
        queue_cmd(150, 359, 0);
        // Headings above 359 wrap around the circle.
        queue_cmd(150, 360, 0);
        queue_cmd(150, 405, 0);
        queue_cmd(150, 511, 0);
        // Rotation alone at both extremes.
        queue_cmd(0, 0, 255);
        queue_cmd(0, 0, -256);
        // Speed and rotation together overshoot full duty and force the rescale.
        queue_cmd(255, 45, 255);
        queue_cmd(-256, 225, -256);
        queue_cmd(255, 0, -256);
        // One wheel mixes to exactly zero, which counts as nonnegative.
        queue_cmd(10, 45, -10);
        // A tiny negative product truncates toward zero rather than down to -1.
        queue_cmd(-1, 0, 0);
        queue_cmd(1, 180, 0);

        // Random requests. Every raw bit pattern of speed and turn is possible; turns are
        // often kept small so that the translation term dominates some of the time.
        for (int n = 0; n < RAND_CMDS; n++) begin
            queue_cmd($urandom_range(511) - 256,
                      ($urandom_range(99) < 15) ? $urandom_range(511, 360)
                                                : $urandom_range(359),
                      ($urandom_range(99) < 30) ? $urandom_range(40) - 20
                                                : $urandom_range(511) - 256);
        end
        total_cmds = pending_cmds.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cmds_taken < total_cmds) begin
            @(posedge aclk);
        end
        while (expected_wheels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_LEN) @(posedge aclk);

        if (mismatch_cnt == 0 && expected_wheels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
